>>> sv/microwire_serial_eeprom_defines.svh
// ---------------------------------------------------------------------------
// microwire serial eeprom assertion macros
// shared concurrent assertion forms, sampled on clk, off during reset
// ---------------------------------------------------------------------------
`ifndef MICROWIRE_SERIAL_EEPROM_DEFINES_SVH
`define MICROWIRE_SERIAL_EEPROM_DEFINES_SVH

// same-cycle implication
`define MSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mse_pkg.sv
// ---------------------------------------------------------------------------
// mse_pkg
// types and constants shared by the microwire serial eeprom modules
// ---------------------------------------------------------------------------
`default_nettype none

package mse_pkg;

  localparam int DEF_WORD_COUNT = 64;
  localparam int CMD_BITS       = 9;
  localparam int DATA_BITS      = 16;
  localparam int ADDR_BITS      = 6;

  localparam int PA_MODE_BIT = 0;
  localparam int PA_DIN_BIT  = 5;
  localparam int PA_SEL_BIT  = 6;
  localparam int PA_CLK_BIT  = 7;

  localparam logic [15:0] ERASED_WORD = 16'hFFFF;
  localparam logic [7:0]  PB_CTRL_HI  = 8'hC0;
  localparam logic [7:0]  PB_FIXED    = 8'h10;
  localparam logic [7:0]  PB_DOUT     = 8'h20;
  localparam logic [7:0]  PB_IN_MASK  = 8'h0F;

  localparam logic [1:0] OP_EXT   = 2'b00;
  localparam logic [1:0] OP_WRITE = 2'b01;
  localparam logic [1:0] OP_READ  = 2'b10;
  localparam logic [1:0] OP_ERASE = 2'b11;

  localparam logic [1:0] SUB_EWDS = 2'b00;
  localparam logic [1:0] SUB_WRAL = 2'b01;
  localparam logic [1:0] SUB_ERAL = 2'b10;
  localparam logic [1:0] SUB_EWEN = 2'b11;

  typedef struct packed {
    logic       req_type;
    logic [7:0] port_a_value;
    logic [7:0] cabinet_inputs;
  } mse_in_item_t;

  typedef struct packed {
    logic [7:0] port_b_value;
    logic       data_out_line;
  } mse_out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_read;
    logic fill;
    logic load_out;
  } mse_cmd_t;

  typedef struct packed {
    logic need_read;
    logic need_fill;
    logic fill_last;
  } mse_status_t;

endpackage

`default_nettype wire

>>> sv/mse_stream_if.sv
// ---------------------------------------------------------------------------
// mse_stream_if
// valid/ready channel carrying one item of a given payload type
// ---------------------------------------------------------------------------
`default_nettype none

interface mse_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/mse_ctrl.sv
// ---------------------------------------------------------------------------
// mse_ctrl
// sequencer: accept, execute, optional read load or store fill, respond
// ---------------------------------------------------------------------------
`default_nettype none
`include "microwire_serial_eeprom_defines.svh"

module mse_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire mse_pkg::mse_status_t st,
  output mse_pkg::mse_cmd_t        cmd
);
  import mse_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDLOAD,
    S_FILL,
    S_RESP
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.capture   = in_valid && (state_r == S_IDLE);
    cmd.exec      = (state_r == S_EXEC);
    cmd.load_read = (state_r == S_RDLOAD);
    cmd.fill      = (state_r == S_FILL);
    cmd.load_out  = (state_r == S_RESP) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (st.need_read) begin
            state_r <= S_RDLOAD;
          end else if (st.need_fill) begin
            state_r <= S_FILL;
          end else begin
            state_r <= S_RESP;
          end
        end
        S_RDLOAD: begin
          state_r <= S_RESP;
        end
        S_FILL: begin
          if (st.fill_last) begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `MSE_ASSERT_NXT(a_accept_exec, in_valid && in_ready, state_r == S_EXEC, "accept not executed")
  `MSE_ASSERT_NXT(a_fill_holds, state_r == S_FILL && !st.fill_last, state_r == S_FILL, "fill cut short")
  `MSE_ASSERT_NXT(a_resp_out, state_r == S_RESP && out_free, out_valid_r && state_r == S_IDLE, "result lost")
  `MSE_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid_r || out_ready, "result overwritten")

endmodule

`default_nettype wire

>>> sv/mse_datapath.sv
// ---------------------------------------------------------------------------
// mse_datapath
// port state, command shifter, read/write shifters and the word store
// ---------------------------------------------------------------------------
`default_nettype none

module mse_datapath #(
  parameter int WORD_COUNT = mse_pkg::DEF_WORD_COUNT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mse_pkg::mse_in_item_t in_data,
  input  wire mse_pkg::mse_cmd_t     cmd,
  output mse_pkg::mse_status_t       st,
  output mse_pkg::mse_out_item_t     out_data
);
  import mse_pkg::*;

  localparam int AW = $clog2(WORD_COUNT);

  mse_in_item_t  item_r;
  mse_out_item_t out_r;

  logic        we_r, we_nxt;
  logic        mode_r, mode_nxt;
  logic        lclk_r, lclk_nxt;
  logic        dout_r, dout_nxt;
  logic [8:0]  sh_r, sh_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [4:0]  rbl_r, rbl_nxt;
  logic [15:0] rw_r;
  logic [4:0]  wbl_r, wbl_nxt;
  logic [15:0] ww_r, ww_nxt;
  logic [5:0]  wa_r, wa_nxt;
  logic        wall_r, wall_nxt;
  logic [AW-1:0] fill_idx_r;

  logic [15:0] mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] valid_r;
  logic [15:0] rd_data_r;
  logic        rd_valid_r;

  logic [7:0]    pa;
  logic          din, sel, pclk;
  logic [8:0]    sh_n;
  logic [3:0]    cnt_n;
  logic          wr_en, clr_all, need_read, need_fill;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [15:0]   wr_data;
  logic [7:0]    pb;

  always_comb begin
    pa   = item_r.port_a_value;
    din  = pa[PA_DIN_BIT];
    sel  = pa[PA_SEL_BIT];
    pclk = pa[PA_CLK_BIT];
    sh_n  = {sh_r[7:0], din};
    cnt_n = cnt_r + 4'd1;

    we_nxt   = we_r;
    mode_nxt = mode_r;
    lclk_nxt = lclk_r;
    dout_nxt = dout_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    rbl_nxt  = rbl_r;
    wbl_nxt  = wbl_r;
    ww_nxt   = ww_r;
    wa_nxt   = wa_r;
    wall_nxt = wall_r;

    wr_en     = 1'b0;
    wr_addr   = wa_r[AW-1:0];
    wr_data   = ww_r;
    clr_all   = 1'b0;
    rd_addr   = sh_n[AW-1:0];
    need_read = 1'b0;
    need_fill = 1'b0;

    if (!item_r.req_type) begin
      mode_nxt = pa[PA_MODE_BIT];
      lclk_nxt = pclk;
      if (!sel) begin
        sh_nxt   = '0;
        cnt_nxt  = '0;
        rbl_nxt  = '0;
        wbl_nxt  = '0;
        dout_nxt = 1'b1;
      end else if (pclk && !lclk_r) begin
        if (rbl_r != 5'd0) begin
          rbl_nxt  = rbl_r - 5'd1;
          dout_nxt = rw_r[rbl_nxt[3:0]];
        end else if (wbl_r != 5'd0) begin
          ww_nxt  = {ww_r[14:0], din};
          wbl_nxt = wbl_r - 5'd1;
          if (wbl_r == 5'd1) begin
            dout_nxt = 1'b1;
            if (we_r) begin
              if (wall_r) begin
                need_fill = 1'b1;
              end else begin
                wr_en   = 1'b1;
                wr_addr = wa_r[AW-1:0];
                wr_data = ww_nxt;
              end
            end
          end
        end else if (cnt_n < 4'(CMD_BITS)) begin
          sh_nxt  = sh_n;
          cnt_nxt = (cnt_n == 4'd1 && !din) ? 4'd0 : cnt_n;
        end else begin
          sh_nxt  = '0;
          cnt_nxt = '0;
          case (sh_n[7:6])
            OP_READ: begin
              need_read = 1'b1;
              rbl_nxt   = 5'(DATA_BITS);
              dout_nxt  = 1'b0;
            end
            OP_WRITE: begin
              wa_nxt   = sh_n[5:0];
              wall_nxt = 1'b0;
              wbl_nxt  = 5'(DATA_BITS);
              ww_nxt   = '0;
            end
            OP_ERASE: begin
              if (we_r) begin
                wr_en   = 1'b1;
                wr_addr = sh_n[AW-1:0];
                wr_data = ERASED_WORD;
              end
            end
            default: begin
              case (sh_n[5:4])
                SUB_EWEN: we_nxt = 1'b1;
                SUB_EWDS: we_nxt = 1'b0;
                SUB_ERAL: clr_all = we_r;
                default: begin
                  wall_nxt = 1'b1;
                  wbl_nxt  = 5'(DATA_BITS);
                  ww_nxt   = '0;
                end
              endcase
            end
          endcase
        end
      end
    end
  end

  assign st.need_read = need_read;
  assign st.need_fill = need_fill;
  assign st.fill_last = (fill_idx_r == AW'(WORD_COUNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      we_r   <= 1'b0;
      mode_r <= 1'b0;
      lclk_r <= 1'b0;
      dout_r <= 1'b1;
      sh_r   <= '0;
      cnt_r  <= '0;
      rbl_r  <= '0;
      rw_r   <= '0;
      wbl_r  <= '0;
      ww_r   <= '0;
      wa_r   <= '0;
      wall_r <= 1'b0;
    end else if (cmd.exec) begin
      we_r   <= we_nxt;
      mode_r <= mode_nxt;
      lclk_r <= lclk_nxt;
      dout_r <= dout_nxt;
      sh_r   <= sh_nxt;
      cnt_r  <= cnt_nxt;
      rbl_r  <= rbl_nxt;
      wbl_r  <= wbl_nxt;
      ww_r   <= ww_nxt;
      wa_r   <= wa_nxt;
      wall_r <= wall_nxt;
    end else if (cmd.load_read) begin
      rw_r <= rd_valid_r ? rd_data_r : ERASED_WORD;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.exec && need_fill) begin
      fill_idx_r <= '0;
    end else if (cmd.fill) begin
      fill_idx_r <= fill_idx_r + AW'(1);
    end
    if (cmd.load_out) begin
      out_r.port_b_value  <= pb;
      out_r.data_out_line <= dout_r;
    end
  end

  // word store, unwritten words read as erased
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= wr_data;
    end else if (cmd.fill) begin
      mem[fill_idx_r] <= ww_r;
    end
    rd_data_r  <= mem[rd_addr];
    rd_valid_r <= valid_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.exec && clr_all) begin
      valid_r <= '0;
    end else if (cmd.exec && wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end else if (cmd.fill) begin
      valid_r[fill_idx_r] <= 1'b1;
    end
  end

  always_comb begin
    if (mode_r) begin
      pb = PB_CTRL_HI | (dout_r ? PB_DOUT : 8'h00) | PB_FIXED
         | (item_r.cabinet_inputs & PB_IN_MASK);
    end else begin
      pb = item_r.cabinet_inputs;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

>>> sv/microwire_serial_eeprom.sv
// ---------------------------------------------------------------------------
// microwire_serial_eeprom
// 64x16 serial eeprom behind a bit-banged port a / port b pair
// ---------------------------------------------------------------------------
// channel   dir  payload
// in_chan   in   req_type, port_a_value, cabinet_inputs
// out_chan  out  port_b_value, data_out_line
//
// one item at a time: accept, execute, then load the result; a read command adds a
// read load step and a completing write-all a fill (walks the store one word a cycle)
// reset is synchronous; the store reads as all ones with no clearing pass
// a waiting result does not block the next accept; a stalled result holds
// ---------------------------------------------------------------------------
`default_nettype none

module microwire_serial_eeprom #(
  parameter int WORD_COUNT = mse_pkg::DEF_WORD_COUNT
) (
  input wire logic   clk,
  input wire logic   rst_n,
  mse_stream_if.sink   in_chan,
  mse_stream_if.source out_chan
);
  import mse_pkg::*;

  mse_cmd_t      cmd;
  mse_status_t   st;
  mse_out_item_t out_data;
  logic          in_ready;
  logic          out_valid;

  mse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .st        (st),
    .cmd       (cmd)
  );

  mse_datapath #(
    .WORD_COUNT (WORD_COUNT)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_chan.data),
    .cmd      (cmd),
    .st       (st),
    .out_data (out_data)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;
  assign out_chan.data  = out_data;

endmodule

`default_nettype wire

>>> sim/microwire_serial_eeprom_test.sv
// ---------------------------------------------------------------------------
// microwire_serial_eeprom_test
// drives bit-banged port a / port b accesses into the serial eeprom, mostly
// well-formed microwire commands with random content plus noise and aborted
// commands, predicts each port b / data-out item with an in-bench eeprom
// model and checks every result item in order under random stalls
// ---------------------------------------------------------------------------
`default_nettype none

module microwire_serial_eeprom_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mse_pkg::*;

  localparam logic REQ_PORT_A = 1'b0;
  localparam logic REQ_PORT_B = 1'b1;

  localparam int STIM_ITEMS     = 1900;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int PRESSURE_AT    = 700;
  localparam int PRESSURE_HOLD  = 400;
  localparam int REPORT_LIMIT   = 10;

  typedef enum {
    XFER_READ, XFER_WRITE, XFER_ERASE, XFER_EWEN, XFER_EWDS,
    XFER_ERAL, XFER_WRAL, XFER_NOISE, XFER_ABORT
  } xfer_kind_t;

  logic clk;
  logic rst_n;

  mse_stream_if #(.payload_t(mse_in_item_t))  in_chan ();
  mse_stream_if #(.payload_t(mse_out_item_t)) out_chan ();

  microwire_serial_eeprom dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // eeprom image and serial state
  logic [15:0] image_words [DEF_WORD_COUNT];
  logic        wr_enable;
  logic        ctrl_mode;
  logic        last_sck;
  logic        din_bit;
  logic        dout_bit;
  logic        wr_all;
  logic [8:0]  cmd_shift;
  logic [3:0]  cmd_count;
  logic [4:0]  rd_left;
  logic [4:0]  wr_left;
  logic [15:0] rd_word;
  logic [15:0] wr_word;
  logic [5:0]  wr_addr;

  mse_in_item_t  port_access_q [$];
  mse_out_item_t readback_q [$];

  int unsigned items_accepted = 0;
  int unsigned total_items    = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned send_gap       = 0;
  int unsigned send_quiet     = 0;
  int unsigned stall_left     = 0;
  int unsigned stall_quiet    = 0;
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;
  logic [5:0]  last_addr      = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_eeprom_model();
    foreach (image_words[i]) image_words[i] = ERASED_WORD;
    wr_enable = 1'b0;
    ctrl_mode = 1'b0;
    last_sck  = 1'b0;
    din_bit   = 1'b0;
    dout_bit  = 1'b1;
    wr_all    = 1'b0;
    cmd_shift = '0;
    cmd_count = '0;
    rd_left   = '0;
    wr_left   = '0;
    rd_word   = '0;
    wr_word   = '0;
    wr_addr   = '0;
  endfunction

  function automatic void eeprom_clock_edge();
    if (rd_left != 0) begin
      rd_left--;
      dout_bit = rd_word[rd_left[3:0]];
      return;
    end
    if (wr_left != 0) begin
      wr_word = {wr_word[14:0], din_bit};
      wr_left--;
      if (wr_left == 0) begin
        if (wr_enable) begin
          if (wr_all) begin
            foreach (image_words[i]) image_words[i] = wr_word;
          end else begin
            image_words[wr_addr] = wr_word;
          end
        end
        dout_bit = 1'b1;
      end
      return;
    end
    cmd_shift = {cmd_shift[7:0], din_bit};
    cmd_count = cmd_count + 4'd1;
    if (cmd_count < CMD_BITS) begin
      // a zero in the start bit position is dropped
      if (cmd_count == 1 && !din_bit) cmd_count = '0;
      return;
    end
    case (cmd_shift[7:6])
      OP_READ: begin
        rd_word  = image_words[cmd_shift[5:0]];
        rd_left  = 5'(DATA_BITS);
        dout_bit = 1'b0;
      end
      OP_EXT: begin
        case (cmd_shift[5:4])
          SUB_EWEN: wr_enable = 1'b1;
          SUB_EWDS: wr_enable = 1'b0;
          SUB_ERAL: begin
            if (wr_enable) begin
              foreach (image_words[i]) image_words[i] = ERASED_WORD;
            end
          end
          default: begin
            wr_all  = 1'b1;
            wr_left = 5'(DATA_BITS);
            wr_word = '0;
          end
        endcase
      end
      OP_WRITE: begin
        wr_addr = cmd_shift[5:0];
        wr_all  = 1'b0;
        wr_left = 5'(DATA_BITS);
        wr_word = '0;
      end
      default: begin
        if (wr_enable) image_words[cmd_shift[5:0]] = ERASED_WORD;
      end
    endcase
    cmd_shift = '0;
    cmd_count = '0;
  endfunction

  function automatic mse_out_item_t eeprom_port_access(mse_in_item_t acc);
    mse_out_item_t res;
    if (acc.req_type == REQ_PORT_A) begin
      ctrl_mode = acc.port_a_value[PA_MODE_BIT];
      din_bit   = acc.port_a_value[PA_DIN_BIT];
      if (!acc.port_a_value[PA_SEL_BIT]) begin
        cmd_shift = '0;
        cmd_count = '0;
        rd_left   = '0;
        wr_left   = '0;
        dout_bit  = 1'b1;
      end else if (acc.port_a_value[PA_CLK_BIT] && !last_sck) begin
        eeprom_clock_edge();
      end
      last_sck = acc.port_a_value[PA_CLK_BIT];
    end
    if (ctrl_mode) begin
      res.port_b_value = PB_CTRL_HI | (dout_bit ? PB_DOUT : 8'h00) | PB_FIXED
                         | (acc.cabinet_inputs & PB_IN_MASK);
    end else begin
      res.port_b_value = acc.cabinet_inputs;
    end
    res.data_out_line = dout_bit;
    return res;
  endfunction

  function automatic int unsigned next_gap(ref int unsigned quiet);
    int unsigned r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) quiet = $urandom_range(30, 80);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [5:0] pick_addr();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return last_addr;
    if (r == 4) last_addr = '0;
    else if (r == 5) last_addr = 6'h3F;
    else if (r < 8) last_addr = 6'($urandom_range(0, 7));
    else last_addr = 6'($urandom);
    return last_addr;
  endfunction

  function automatic xfer_kind_t pick_xfer();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return XFER_READ;
    if (r < 55) return XFER_WRITE;
    if (r < 63) return XFER_ERASE;
    if (r < 72) return XFER_EWEN;
    if (r < 76) return XFER_EWDS;
    if (r < 79) return XFER_ERAL;
    if (r < 83) return XFER_WRAL;
    if (r < 92) return XFER_NOISE;
    return XFER_ABORT;
  endfunction

  task automatic add_access(logic req, logic [7:0] pa, logic [7:0] cab);
    mse_in_item_t acc;
    acc.req_type       = req;
    acc.port_a_value   = pa;
    acc.cabinet_inputs = cab;
    port_access_q.push_back(acc);
  endtask

  // unused port a bits and the mode bit stay random
  task automatic drive_port_a(logic sel, logic sck, logic din);
    logic [7:0] pa;
    pa              = 8'($urandom);
    pa[PA_SEL_BIT]  = sel;
    pa[PA_CLK_BIT]  = sck;
    pa[PA_DIN_BIT]  = din;
    add_access(REQ_PORT_A, pa, 8'($urandom));
    if ($urandom_range(0, 5) == 0) add_access(REQ_PORT_B, 8'($urandom), 8'($urandom));
  endtask

  task automatic clock_in(logic din);
    drive_port_a(1'b1, 1'b0, din);
    drive_port_a(1'b1, 1'b1, din);
  endtask

  task automatic send_command(logic [1:0] op, logic [5:0] addr);
    clock_in(1'b1);
    clock_in(op[1]);
    clock_in(op[0]);
    for (int i = 5; i >= 0; i--) clock_in(addr[i]);
  endtask

  task automatic shift_word(logic [15:0] w);
    for (int i = 15; i >= 0; i--) clock_in(w[i]);
  endtask

  task automatic add_xfer(xfer_kind_t kind);
    logic [5:0]  addr;
    logic [15:0] word;
    addr = pick_addr();
    word = 16'($urandom);
    repeat ($urandom_range(0, 2)) clock_in(1'b0);
    case (kind)
      XFER_READ: begin
        send_command(OP_READ, addr);
        repeat (DATA_BITS) clock_in(1'($urandom));
        // clocks past the last read bit start a new command
        if ($urandom_range(0, 3) == 0) clock_in(1'($urandom));
      end
      XFER_WRITE: begin
        send_command(OP_WRITE, addr);
        shift_word(word);
      end
      XFER_ERASE: send_command(OP_ERASE, addr);
      XFER_EWEN:  send_command(OP_EXT, {SUB_EWEN, 4'($urandom)});
      XFER_EWDS:  send_command(OP_EXT, {SUB_EWDS, 4'($urandom)});
      XFER_ERAL:  send_command(OP_EXT, {SUB_ERAL, 4'($urandom)});
      XFER_WRAL: begin
        send_command(OP_EXT, {SUB_WRAL, 4'($urandom)});
        shift_word(word);
      end
      XFER_NOISE: begin
        repeat ($urandom_range(1, 8)) add_access(1'($urandom), 8'($urandom), 8'($urandom));
      end
      default: begin
        // command cut short by a deselect
        clock_in(1'b1);
        repeat ($urandom_range(1, 24)) clock_in(1'($urandom));
      end
    endcase
    drive_port_a(1'b0, 1'($urandom), 1'($urandom));
  endtask

  task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin : drive_port_access
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        readback_q.push_back(eeprom_port_access(in_chan.data));
        items_accepted++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_chan.valid <= 1'b0;
        end else if (port_access_q.size() > 0) begin
          in_chan.data  <= port_access_q.pop_front();
          in_chan.valid <= 1'b1;
          send_gap = next_gap(send_quiet);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : drive_result_ready
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else if (!hold_done && items_accepted >= PRESSURE_AT) begin
      // long hold-off so the block backs up into its input
      hold_done = 1'b1;
      hold_left = PRESSURE_HOLD;
      out_chan.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 2) == 0) ? next_gap(stall_quiet) : 0;
      out_chan.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin : check_port_b
    mse_out_item_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (readback_q.size() == 0) begin
        note_mismatch("unexpected item", '0, 16'(out_chan.data));
      end else begin
        want = readback_q.pop_front();
        if (out_chan.data.port_b_value !== want.port_b_value) begin
          note_mismatch("port_b_value", 16'(want.port_b_value),
                        16'(out_chan.data.port_b_value));
        end
        if (out_chan.data.data_out_line !== want.data_out_line) begin
          note_mismatch("data_out_line", 16'(want.data_out_line),
                        16'(out_chan.data.data_out_line));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("microwire_serial_eeprom_test NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    xfer_kind_t opening [18] = '{
      XFER_READ, XFER_ERAL, XFER_WRITE, XFER_READ, XFER_EWEN, XFER_WRITE,
      XFER_READ, XFER_ERASE, XFER_READ, XFER_WRAL, XFER_READ, XFER_ERAL,
      XFER_READ, XFER_EWDS, XFER_WRITE, XFER_READ, XFER_ABORT, XFER_EWEN
    };
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    out_chan.ready = 1'b0;
    reset_eeprom_model();

    add_access(REQ_PORT_B, 8'h00, 8'h00);
    add_access(REQ_PORT_B, 8'hFF, 8'hFF);
    add_access(REQ_PORT_A, 8'h01, 8'h00);  // control mode, deselected
    add_access(REQ_PORT_B, 8'h00, 8'hFF);
    add_access(REQ_PORT_B, 8'hFF, 8'h00);
    add_access(REQ_PORT_A, 8'hFF, 8'hFF);  // rising clock, start bit
    add_access(REQ_PORT_A, 8'hFF, 8'hA5);  // clock held high
    add_access(REQ_PORT_A, 8'h7F, 8'h5A);
    add_access(REQ_PORT_A, 8'h00, 8'hFF);  // deselect mid command
    add_access(REQ_PORT_A, 8'h41, 8'h0F);
    add_access(REQ_PORT_A, 8'hC1, 8'hF0);  // leading zero dropped
    add_access(REQ_PORT_A, 8'h9F, 8'h3C);  // deselected with clock still high
    add_access(REQ_PORT_A, 8'hC1, 8'hC3);  // select with clock already high
    add_access(REQ_PORT_A, 8'h61, 8'h00);
    add_access(REQ_PORT_A, 8'hE1, 8'hFF);
    add_access(REQ_PORT_B, 8'h7F, 8'h80);
    add_access(REQ_PORT_A, 8'h1E, 8'h01);

    foreach (opening[i]) add_xfer(opening[i]);
    while (port_access_q.size() < STIM_ITEMS) add_xfer(pick_xfer());
    total_items = port_access_q.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (items_accepted < total_items) @(posedge clk);
    while (readback_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("microwire_serial_eeprom_test OK");
    end else begin
      $display("microwire_serial_eeprom_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
